>>> rtl/fct_pkg.sv
package fct_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = ADDR_W + 1;
    localparam int ENT_W         = 16;
    localparam int CFG_W         = 13;
    localparam int CL_EXT_W      = ENT_W + 1;

    localparam logic [ENT_W-1:0] ENT_FREE   = 16'h0000;
    localparam logic [ENT_W-1:0] ENT_RSV_LO = 16'hfff0;
    localparam logic [ENT_W-1:0] ENT_RSV_HI = 16'hfff6;
    localparam logic [ENT_W-1:0] ENT_BAD    = 16'hfff7;
    localparam logic [ENT_W-1:0] ENT_END_LO = 16'hfff8;
    localparam logic [ENT_W-1:0] ENT_END_HI = 16'hffff;

    typedef enum logic [1:0] {
        REQ_NEXT   = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_FREE   = 2'd2,
        REQ_LOAD   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_END   = 2'd3
    } stat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_LINK,
        ST_RESP
    } state_t;

    function automatic logic ends_chain(input logic [ENT_W-1:0] v);
        logic r;
        r = (v == ENT_FREE) || (v == ENT_BAD)
            || ((v >= ENT_RSV_LO) && (v <= ENT_RSV_HI))
            || (v >= ENT_END_LO);
        return r;
    endfunction

endpackage

>>> rtl/fct_ram.sv
module fct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/fat16_cluster_table_engine.sv
// FAT16 cluster table engine.
// Input channel (in_valid/in_ready): one request per beat, req_type with
// cluster and entry_value. Output channel (out_valid/out_ready): one result
// beat per request, result_cluster and status, in request order.
// Config channel (cfg_valid/cfg_ready): entries_in_use, always ready; write
// it only while no request is in flight.
// The table lives in one 4096 x 16 RAM with a registered read.
// After reset a clearing pass writes every entry to zero, one per cycle,
// with in_ready low.
// Free, load and range errors go from accept straight to the response state;
// get next first reads its entry in a lookup state. A new request is taken in
// the cycle the result enters the output register, so free and load sustain one
// request per cycle while the receiver is ready; get next takes none in its lookup.
// Append reads one entry per cycle from entry 0 through the single read
// port, over the first min(entries_in_use, 4096) entries, and marks the first free
// one as end of chain; a named cluster of 2 or more is linked to it. No free one: full.
// One output register holds the result; while out_ready is low the result
// waits there and the engine stops taking new requests once its next result
// is ready.
module fat16_cluster_table_engine
    import fct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       req_type,
    input  logic [ENT_W-1:0] cluster,
    input  logic [ENT_W-1:0] entry_value,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [ENT_W-1:0] result_cluster,
    output logic [1:0]       status,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  lim_reg, lim_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [ADDR_W-1:0] cl_reg, cl_next;
    logic              link_reg, link_next;
    logic [ENT_W-1:0]  res_reg, res_next;
    logic [1:0]        st_reg, st_next;
    logic [CFG_W-1:0]  eiu_reg, eiu_next;

    logic              out_valid_reg, out_valid_next;
    logic [ENT_W-1:0]  result_cluster_reg, result_cluster_next;
    logic [1:0]        status_reg, status_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;

    logic             out_free;
    logic             take;
    logic             cl_range;
    logic             cl_low;
    logic [CNT_W-1:0] lim_calc;
    logic             scan_hit;
    logic             scan_more;

    fct_ram #(
        .WIDTH(ENT_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_RESP) && out_free);
    assign take      = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cl_range  = {1'b0, cluster} >= CL_EXT_W'(TABLE_ENTRIES);
    assign cl_low    = cluster < 16'd2;
    assign lim_calc  = (32'(eiu_reg) > TABLE_ENTRIES) ? CNT_W'(TABLE_ENTRIES)
                                                      : CNT_W'(eiu_reg);
    assign scan_hit  = pend_reg && (ram_rdata == ENT_FREE);
    assign scan_more = idx_reg < lim_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == ADDR_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_RESP;
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = link_reg ? ST_LINK : ST_RESP;
                end
                else if (!pend_reg && !scan_more)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_LINK:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (take)
        begin
            state_next = ST_RESP;
            if (!cl_range)
            begin
                if ((req_type == REQ_NEXT) && !cl_low)
                begin
                    state_next = ST_LOOK;
                end
                else if ((req_type == REQ_APPEND) && (lim_calc != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
        end
    end

    always_comb
    begin
        clr_next            = clr_reg;
        idx_next            = idx_reg;
        lim_next            = lim_reg;
        pend_next           = pend_reg;
        pend_addr_next      = pend_addr_reg;
        cl_next             = cl_reg;
        link_next           = link_reg;
        res_next            = res_reg;
        st_next             = st_reg;
        eiu_next            = eiu_reg;
        ram_we              = 1'b0;
        ram_waddr           = cl_reg;
        ram_wdata           = ENT_FREE;
        ram_raddr           = cluster[ADDR_W-1:0];
        out_valid_next      = out_valid_reg && !out_ready;
        result_cluster_next = result_cluster_reg;
        status_next         = status_reg;

        if (cfg_valid && cfg_ready)
        begin
            eiu_next = cfg_data;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = ENT_FREE;
                clr_next  = clr_reg + 1'b1;
            end
            ST_LOOK:
            begin
                if (ends_chain(ram_rdata))
                begin
                    res_next = '0;
                    st_next  = STAT_END;
                end
                else
                begin
                    res_next = ram_rdata;
                    st_next  = STAT_OK;
                end
            end
            ST_SCAN:
            begin
                ram_raddr      = idx_reg[ADDR_W-1:0];
                pend_next      = scan_more;
                pend_addr_next = idx_reg[ADDR_W-1:0];
                if (scan_more)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (scan_hit)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ENT_END_HI;
                    res_next  = ENT_W'(pend_addr_reg);
                    st_next   = STAT_OK;
                end
                else if (!pend_reg && !scan_more)
                begin
                    res_next = '0;
                    st_next  = STAT_FULL;
                end
            end
            ST_LINK:
            begin
                ram_we    = 1'b1;
                ram_waddr = cl_reg;
                ram_wdata = res_reg;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    result_cluster_next = res_reg;
                    status_next         = st_reg;
                end
            end
            ST_IDLE:
            begin
                res_next = res_reg;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase

        if (take)
        begin
            cl_next   = cluster[ADDR_W-1:0];
            link_next = !cl_low;
            res_next  = '0;
            st_next   = STAT_OK;
            if (cl_range)
            begin
                st_next = STAT_RANGE;
            end
            else
            begin
                unique case (req_type)
                    REQ_NEXT:
                    begin
                        if (cl_low)
                        begin
                            st_next = STAT_RANGE;
                        end
                    end
                    REQ_APPEND:
                    begin
                        idx_next  = '0;
                        pend_next = 1'b0;
                        lim_next  = lim_calc;
                        if (lim_calc == '0)
                        begin
                            st_next = STAT_FULL;
                        end
                    end
                    REQ_FREE:
                    begin
                        if (cl_low)
                        begin
                            st_next = STAT_RANGE;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = cluster[ADDR_W-1:0];
                            ram_wdata = ENT_FREE;
                        end
                    end
                    REQ_LOAD:
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cluster[ADDR_W-1:0];
                        ram_wdata = entry_value;
                    end
                    default:
                    begin
                        st_next = STAT_OK;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            eiu_reg       <= CFG_W'(4096);
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            eiu_reg       <= eiu_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg            <= idx_next;
        lim_reg            <= lim_next;
        pend_addr_reg      <= pend_addr_next;
        cl_reg             <= cl_next;
        link_reg           <= link_next;
        res_reg            <= res_next;
        st_reg             <= st_next;
        result_cluster_reg <= result_cluster_next;
        status_reg         <= status_next;
    end

    assign out_valid      = out_valid_reg;
    assign result_cluster = result_cluster_reg;
    assign status         = status_reg;

`ifndef ASSERT_OFF
    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("request taken during clearing pass");

    a_scan_write_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && ram_we) |-> (ram_wdata == ENT_END_HI))
        else $error("scan wrote something other than end marker");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg <= lim_reg))
        else $error("scan index beyond limit");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != STAT_OK)) |-> (result_cluster_reg == '0))
        else $error("nonzero cluster with error status");
`endif

endmodule

>>> bench/fct_table_checker.sv
`timescale 1ns / 100ps

module fct_table_checker
    import fct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [1:0]       req_type,
    input  logic [ENT_W-1:0] cluster,
    input  logic [ENT_W-1:0] entry_value,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [ENT_W-1:0] result_cluster,
    input  logic [1:0]       status,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    output int unsigned      pending,
    output int unsigned      errors,
    output logic [ENT_W-1:0] recent_alloc
);

    typedef struct packed {
        logic [ENT_W-1:0] cl_out;
        stat_t            st;
    } fat_reply_t;

    logic [ENT_W-1:0] fat_copy [TABLE_ENTRIES];
    logic [CFG_W-1:0] scan_span;
    fat_reply_t       due_replies [$];
    fat_reply_t       head;

    // free, reserved, bad and end markers all stop a chain
    function automatic logic is_chain_end(input logic [ENT_W-1:0] v);
        return (v == ENT_FREE) || (v >= ENT_RSV_LO);
    endfunction

    function automatic fat_reply_t apply_request(input req_t kind,
                                                 input logic [ENT_W-1:0] cl,
                                                 input logic [ENT_W-1:0] val);
        fat_reply_t r;
        int         limit;
        int         slot;
        int         i;
        r.cl_out = '0;
        r.st     = STAT_OK;
        limit    = (scan_span > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(scan_span);
        if (cl >= TABLE_ENTRIES)
        begin
            r.st = STAT_RANGE;
        end
        else
        begin
            case (kind)
                REQ_NEXT:
                begin
                    if (cl < 2)
                        r.st = STAT_RANGE;
                    else if (is_chain_end(fat_copy[cl]))
                        r.st = STAT_END;
                    else
                        r.cl_out = fat_copy[cl];
                end
                REQ_APPEND:
                begin
                    slot = -1;
                    i    = 0;
                    while (slot < 0 && i < limit)
                    begin
                        if (fat_copy[i] == ENT_FREE)
                            slot = i;
                        i++;
                    end
                    if (slot < 0)
                    begin
                        r.st = STAT_FULL;
                    end
                    else
                    begin
                        fat_copy[slot] = ENT_END_HI;
                        if (cl >= 2)
                            fat_copy[cl] = ENT_W'(slot);
                        r.cl_out = ENT_W'(slot);
                    end
                end
                REQ_FREE:
                begin
                    if (cl < 2)
                        r.st = STAT_RANGE;
                    else
                        fat_copy[cl] = ENT_FREE;
                end
                default:
                begin
                    fat_copy[cl] = val;
                end
            endcase
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        errors++;
        if (errors <= 40)
            $display("%0t ns: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TABLE_ENTRIES; k++)
                fat_copy[k] = ENT_FREE;
            scan_span = CFG_W'(TABLE_ENTRIES);
            due_replies.delete();
            errors = 0;
            recent_alloc <= '0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                scan_span = cfg_data;
            if (out_valid && out_ready)
            begin
                if (due_replies.size() == 0)
                begin
                    flag_mismatch($sformatf("result beat with nothing pending: %h status %0d",
                                            result_cluster, status));
                end
                else
                begin
                    head = due_replies.pop_front();
                    if (result_cluster !== head.cl_out)
                        flag_mismatch($sformatf("result_cluster %h, want %h",
                                                result_cluster, head.cl_out));
                    if (status !== head.st)
                        flag_mismatch($sformatf("status %0d, want %0d", status, head.st));
                end
            end
            if (in_valid && in_ready)
            begin
                head = apply_request(req_t'(req_type), cluster, entry_value);
                if (req_t'(req_type) == REQ_APPEND && head.st == STAT_OK)
                    recent_alloc <= head.cl_out;
                due_replies.push_back(head);
            end
            pending <= due_replies.size();
        end
    end

endmodule

>>> bench/tb_fat16_cluster_table_engine.sv
`timescale 1ns / 100ps

module tb_fat16_cluster_table_engine;
    import fct_pkg::*;

    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned PHASES      = 16;
    localparam int unsigned PHASE_BEATS = 96;

    logic             clk;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic             in_ready;
    logic [1:0]       req_type    = REQ_NEXT;
    logic [ENT_W-1:0] cluster     = '0;
    logic [ENT_W-1:0] entry_value = '0;
    logic             out_valid;
    logic             out_ready   = 1'b0;
    logic [ENT_W-1:0] result_cluster;
    logic [1:0]       status;
    logic             cfg_valid   = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data    = '0;

    int unsigned      pending;
    int unsigned      errors;
    logic [ENT_W-1:0] recent_alloc;
    bit               calm         = 1'b0;
    int unsigned      hold_asks    = 0;
    int unsigned      hold_done    = 0;
    int unsigned      quiet_cycles = 0;

    fat16_cluster_table_engine uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .cluster        (cluster),
        .entry_value    (entry_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_cluster (result_cluster),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    fct_table_checker table_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .cluster        (cluster),
        .entry_value    (entry_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_cluster (result_cluster),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .pending        (pending),
        .errors         (errors),
        .recent_alloc   (recent_alloc)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned idle_gap();
        int unsigned roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic offer_request(input req_t kind, input logic [ENT_W-1:0] cl,
                                 input logic [ENT_W-1:0] val);
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        cluster     <= cl;
        entry_value <= val;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_span(input logic [CFG_W-1:0] span);
        cfg_valid <= 1'b1;
        cfg_data  <= span;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mostly chain building and walking inside a small window, some noise
    task automatic random_request(input int unsigned span);
        int unsigned      pick;
        logic [ENT_W-1:0] cl;
        logic [ENT_W-1:0] val;
        req_t             kind;
        pick = $urandom_range(0, 99);
        cl   = ENT_W'($urandom_range(0, span));
        val  = ENT_W'($urandom);
        kind = REQ_LOAD;
        if (pick < 12)
        begin
            kind = req_t'($urandom_range(0, 3));
            cl   = ENT_W'($urandom);
        end
        else if (pick < 30)
        begin
            kind = REQ_APPEND;
            cl   = ($urandom_range(0, 3) == 0) ? ENT_W'($urandom_range(0, 1)) : recent_alloc;
        end
        else if (pick < 42)
        begin
            kind = REQ_APPEND;
        end
        else if (pick < 62)
        begin
            kind = REQ_NEXT;
            if ($urandom_range(0, 1))
                cl = recent_alloc;
        end
        else if (pick < 80)
        begin
            kind = REQ_FREE;
            if ($urandom_range(0, 1))
                cl = recent_alloc;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: val = ENT_W'($urandom_range(0, span));
                1: val = ENT_RSV_LO + ENT_W'($urandom_range(0, 15));
                2: val = ENT_W'($urandom_range(0, 1));
                default: ;
            endcase
        end
        offer_request(kind, cl, val);
    endtask

    initial
    begin
        int unsigned gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_asks != hold_done)
            begin
                hold_done++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                gap = idle_gap();
                if (gap != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("fat16_cluster_table_engine test failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int unsigned span_plan [PHASES];
        int unsigned window;
        span_plan = '{4096, 1, 8191, 0, 6, 4096, 24, 2,
                      4095, 12, 8191, 40, 4096, 3, 100, 4096};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // entries 0 and 1 are free after reset, so the first appends take them
        offer_request(REQ_APPEND, 16'd0, 16'd0);
        offer_request(REQ_APPEND, 16'd1, 16'hffff);
        offer_request(REQ_LOAD, 16'd0, ENT_END_LO);
        offer_request(REQ_APPEND, 16'd0, 16'd0);
        offer_request(REQ_APPEND, 16'd2, 16'd0);
        offer_request(REQ_NEXT, 16'd2, 16'd0);
        offer_request(REQ_NEXT, 16'd3, 16'd0);
        offer_request(REQ_NEXT, 16'd1, 16'd0);
        offer_request(REQ_FREE, 16'd0, 16'd0);
        offer_request(REQ_NEXT, 16'd4, 16'd0);
        // named cluster is the first free one: ends up pointing at itself
        offer_request(REQ_APPEND, 16'd4, 16'd0);
        offer_request(REQ_NEXT, 16'd4, 16'd0);
        offer_request(REQ_LOAD, 16'd5, 16'd1);
        offer_request(REQ_NEXT, 16'd5, 16'd0);
        offer_request(REQ_LOAD, 16'd6, ENT_BAD);
        offer_request(REQ_NEXT, 16'd6, 16'd0);
        offer_request(REQ_LOAD, 16'd7, 16'hffef);
        offer_request(REQ_NEXT, 16'd7, 16'd0);
        offer_request(REQ_LOAD, 16'd4095, ENT_RSV_LO);
        offer_request(REQ_NEXT, 16'd4095, 16'd0);
        offer_request(REQ_NEXT, 16'd4096, 16'd0);
        offer_request(REQ_APPEND, 16'hffff, 16'd0);
        offer_request(REQ_FREE, 16'd4096, 16'd0);
        offer_request(REQ_LOAD, 16'hffff, 16'hffff);
        offer_request(REQ_FREE, 16'd2, 16'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_span(CFG_W'(span_plan[p]));
            calm   = (p % 4 == 1);
            window = $urandom_range(6, 72);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if (p == 5 && n == 20)
                    hold_asks++;
                if (p == 9 && n == 48)
                    settle();
                random_request(window);
            end
        end

        settle();
        if (errors == 0)
            $display("fat16_cluster_table_engine test passed");
        else
            $display("fat16_cluster_table_engine test failed");
        $finish;
    end

endmodule
